// File: hdl/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg
// shared types and constants for the lidar point camera projection block
// ----------------------------------------------------------------------------
package lpcp_pkg;

  // coefficient table geometry
  localparam int COEF_COUNT        = 21;
  localparam int COEF_W            = 32;
  localparam int COEF_IDX_W        = 5;
  localparam int INTR_BASE         = 12;
  localparam int FRAC_BITS_DEFAULT = 16;

  // point and image dimension widths
  localparam int POINT_W    = 32;
  localparam int DIM_W      = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_X_LOW  = 3'd0,
    CFG_X_HIGH = 3'd1,
    CFG_Z_LOW  = 3'd2,
    CFG_Z_HIGH = 3'd3,
    CFG_IMG_W  = 3'd4,
    CFG_IMG_H  = 3'd5
  } cfg_reg_e;

  // request mode codes
  typedef enum logic {
    MODE_PROJECT = 1'b0,
    MODE_LOAD    = 1'b1
  } mode_e;

  // one lidar point
  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
  } point_t;

  // whole coefficient table, slot 0 in the low word
  typedef logic [COEF_COUNT-1:0][COEF_W-1:0] coef_tab_t;

  // image bounds handed to the back end
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } img_dim_t;

endpackage

// File: hdl/lpcp_queue.sv
// ----------------------------------------------------------------------------
// lpcp_queue
// two-entry point queue between the front end and the arithmetic pipeline
// ----------------------------------------------------------------------------
module lpcp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lpcp_pkg::point_t    data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output lpcp_pkg::point_t    data_o
);

  lpcp_pkg::point_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

// File: hdl/lpcp_front.sv
// ----------------------------------------------------------------------------
// lpcp_front
// request intake: configuration registers, coefficient loads, range gate
// ----------------------------------------------------------------------------
module lpcp_front #(
  parameter int FRAC_BITS = lpcp_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lpcp_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   mode_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]    point_x_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]    point_y_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]    point_z_i,
  input  logic [lpcp_pkg::COEF_IDX_W-1:0]        coef_index_i,
  input  logic signed [lpcp_pkg::COEF_W-1:0]     coef_value_i,
  input  logic                                   q_full_i,
  input  logic                                   q_valid_i,
  input  logic                                   back_busy_i,
  output logic                                   push_o,
  output lpcp_pkg::point_t                       point_o,
  output lpcp_pkg::coef_tab_t                    coef_o,
  output lpcp_pkg::img_dim_t                     dim_o
);

  localparam logic signed [31:0] X_HIGH_RST = 32'(100 << FRAC_BITS);
  localparam logic signed [31:0] Z_LOW_RST  = 32'(-((16 * (1 << FRAC_BITS) + 10) / 20));
  localparam logic signed [31:0] Z_HIGH_RST = 32'(2 << FRAC_BITS);

  logic signed [31:0]             x_low_q, x_high_q, z_low_q, z_high_q;
  logic [lpcp_pkg::DIM_W-1:0]     img_w_q, img_h_q;
  lpcp_pkg::coef_tab_t            coef_q;
  logic                           is_load;
  logic                           accept;
  logic                           in_range;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= '0;
      x_high_q <= X_HIGH_RST;
      z_low_q  <= Z_LOW_RST;
      z_high_q <= Z_HIGH_RST;
      img_w_q  <= 13'd640;
      img_h_q  <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lpcp_pkg::CFG_X_LOW:  x_low_q  <= cfg_wdata_i;
        lpcp_pkg::CFG_X_HIGH: x_high_q <= cfg_wdata_i;
        lpcp_pkg::CFG_Z_LOW:  z_low_q  <= cfg_wdata_i;
        lpcp_pkg::CFG_Z_HIGH: z_high_q <= cfg_wdata_i;
        lpcp_pkg::CFG_IMG_W:  img_w_q  <= cfg_wdata_i[lpcp_pkg::DIM_W-1:0];
        lpcp_pkg::CFG_IMG_H:  img_h_q  <= cfg_wdata_i[lpcp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // loads wait for the queue and pipeline to drain so in-flight points keep their table
  assign is_load    = (mode_i == lpcp_pkg::MODE_LOAD);
  assign in_stall_o = is_load ? (q_valid_i || back_busy_i) : q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // coefficient table, contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (accept && is_load && (coef_index_i < lpcp_pkg::COEF_IDX_W'(lpcp_pkg::COEF_COUNT))) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // raw range gate on x and z
  assign in_range = (point_x_i >= x_low_q) && (point_x_i <= x_high_q) &&
                    (point_z_i >= z_low_q) && (point_z_i <= z_high_q);

  assign push_o       = accept && !is_load && in_range;
  assign point_o.x    = point_x_i;
  assign point_o.y    = point_y_i;
  assign point_o.z    = point_z_i;
  assign coef_o       = coef_q;
  assign dim_o.width  = img_w_q;
  assign dim_o.height = img_h_q;

endmodule

// File: hdl/lpcp_back.sv
// ----------------------------------------------------------------------------
// lpcp_back
// arithmetic pipeline: rigid transform, intrinsics, image bounds, result register
// ----------------------------------------------------------------------------
module lpcp_back #(
  parameter int FRAC_BITS = lpcp_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  lpcp_pkg::point_t                     q_data_i,
  output logic                                 pop_o,
  input  lpcp_pkg::coef_tab_t                  coef_i,
  input  lpcp_pkg::img_dim_t                   dim_i,
  output logic                                 busy_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lpcp_pkg::POINT_W-1:0]  cam_x_o,
  output logic signed [lpcp_pkg::POINT_W-1:0]  cam_y_o,
  output logic signed [lpcp_pkg::POINT_W-1:0]  cam_z_o
);

  localparam int SW = 66;
  localparam int MW = 79;
  localparam logic signed [SW-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [SW-1:0] SAT_MIN = -66'sd2147483648;

  logic adv;

  logic               s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic signed [63:0] tp_q [3][3], tp_d [3][3];
  logic signed [31:0] cam_q [3], cam_d [3];
  logic signed [31:0] cam3_q [3], cam4_q [3], cam5_q [3];
  logic signed [63:0] ip_q [3][3], ip_d [3][3];
  logic signed [SW-1:0] uvw_q [3], uvw_d [3];
  logic signed [31:0] pt [3];

  // stage five terms
  logic [SW-1:0] au, av, aw;
  logic          wz_d, wz_q;
  logic          su_d, su_q, sv_d, sv_q;
  logic          ult_d, ult_q, vlt_d, vlt_q;
  logic [45:0]   mx_lo_d, mx_lo_q, mx_hi_d, mx_hi_q;
  logic [45:0]   my_lo_d, my_lo_q, my_hi_d, my_hi_q;
  logic [SW-1:0] au_q, av_q;
  logic          wnz_d, wnz_q, hnz_d, hnz_q;

  logic [MW-1:0] lim_x, lim_y;
  logic          keep;
  logic          out_valid_q;
  logic signed [31:0] out_q [3];

  // whole pipeline moves when the result register can take a value
  assign adv    = !out_valid_q || !out_stall_i;
  assign pop_o  = q_valid_i && adv;
  assign busy_o = s1_v_q || s2_v_q || s3_v_q || s4_v_q || s5_v_q;

  assign pt[0] = q_data_i.x;
  assign pt[1] = q_data_i.y;
  assign pt[2] = q_data_i.z;

  // transform products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tp_d[r][c] = $signed(coef_i[r*4+c]) * pt[c];
      end
    end
  end

  // transform sums, floor, translation and saturation
  always_comb begin
    logic signed [SW-1:0] s;
    for (int r = 0; r < 3; r++) begin
      s = (SW'(tp_q[r][0]) + SW'(tp_q[r][1]) + SW'(tp_q[r][2])) >>> FRAC_BITS;
      s = s + SW'($signed(coef_i[r*4+3]));
      if (s > SAT_MAX) begin
        cam_d[r] = 32'sh7fffffff;
      end else if (s < SAT_MIN) begin
        cam_d[r] = 32'sh80000000;
      end else begin
        cam_d[r] = s[31:0];
      end
    end
  end

  // intrinsic products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ip_d[r][c] = $signed(coef_i[lpcp_pkg::INTR_BASE+r*3+c]) * cam_q[c];
      end
    end
  end

  // intrinsic sums and floor
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      uvw_d[r] = (SW'(ip_q[r][0]) + SW'(ip_q[r][1]) + SW'(ip_q[r][2])) >>> FRAC_BITS;
    end
  end

  // magnitudes, signs and bound products for the truncating divide test
  always_comb begin
    au      = uvw_q[0][SW-1] ? SW'(-uvw_q[0]) : uvw_q[0];
    av      = uvw_q[1][SW-1] ? SW'(-uvw_q[1]) : uvw_q[1];
    aw      = uvw_q[2][SW-1] ? SW'(-uvw_q[2]) : uvw_q[2];
    wz_d    = (uvw_q[2] == '0);
    su_d    = (uvw_q[0][SW-1] == uvw_q[2][SW-1]) || (uvw_q[0] == '0);
    sv_d    = (uvw_q[1][SW-1] == uvw_q[2][SW-1]) || (uvw_q[1] == '0);
    ult_d   = (au < aw);
    vlt_d   = (av < aw);
    mx_lo_d = 46'(dim_i.width)  * 46'(aw[32:0]);
    mx_hi_d = 46'(dim_i.width)  * 46'(aw[SW-1:33]);
    my_lo_d = 46'(dim_i.height) * 46'(aw[32:0]);
    my_hi_d = 46'(dim_i.height) * 46'(aw[SW-1:33]);
    wnz_d   = (dim_i.width != '0);
    hnz_d   = (dim_i.height != '0);
  end

  // pixel inside test: same sign needs |u| < W*|w|, opposite sign needs |u| < |w|
  always_comb begin
    lim_x = (MW'(mx_hi_q) << 33) + MW'(mx_lo_q);
    lim_y = (MW'(my_hi_q) << 33) + MW'(my_lo_q);
    keep  = s5_v_q && !wz_q && wnz_q && hnz_q &&
            (su_q ? (MW'(au_q) < lim_x) : ult_q) &&
            (sv_q ? (MW'(av_q) < lim_y) : vlt_q);
  end

  // stage valids and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= pop_o;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      out_valid_q <= keep;
    end
  end

  // pipeline data
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tp_q    <= tp_d;
      cam_q   <= cam_d;
      ip_q    <= ip_d;
      cam3_q  <= cam_q;
      uvw_q   <= uvw_d;
      cam4_q  <= cam3_q;
      cam5_q  <= cam4_q;
      wz_q    <= wz_d;
      su_q    <= su_d;
      sv_q    <= sv_d;
      ult_q   <= ult_d;
      vlt_q   <= vlt_d;
      mx_lo_q <= mx_lo_d;
      mx_hi_q <= mx_hi_d;
      my_lo_q <= my_lo_d;
      my_hi_q <= my_hi_d;
      au_q    <= au;
      av_q    <= av;
      wnz_q   <= wnz_d;
      hnz_q   <= hnz_d;
      if (keep) begin
        out_q <= cam5_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign cam_x_o     = out_q[0];
  assign cam_y_o     = out_q[1];
  assign cam_z_o     = out_q[2];

endmodule

// File: hdl/lidar_point_camera_projection.sv
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// range gate, rigid transform and pinhole projection of lidar points
// ----------------------------------------------------------------------------
// Takes one point request per cycle while the result side does not stall and
// raises a kept point's camera-frame coordinates once it has passed the queue
// entry and the arithmetic pipeline registers (transform products, sums,
// intrinsic products, sums, bound products, result register). Points that fail the
// range gate, land outside the image or have zero depth give no result. A
// coefficient load request is held until every accepted point has left the
// queue and the pipeline stages ahead of the result register, and is held
// longer while the result side stalls.
module lidar_point_camera_projection #(
  parameter int FRAC_BITS = lpcp_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lpcp_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]  point_x_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]  point_y_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]  point_z_i,
  input  logic [lpcp_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic signed [lpcp_pkg::COEF_W-1:0]   coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lpcp_pkg::POINT_W-1:0]  cam_x_o,
  output logic signed [lpcp_pkg::POINT_W-1:0]  cam_y_o,
  output logic signed [lpcp_pkg::POINT_W-1:0]  cam_z_o
);

  logic                 push, q_full, q_valid, pop, back_busy;
  lpcp_pkg::point_t     push_pt, q_pt;
  lpcp_pkg::coef_tab_t  coef;
  lpcp_pkg::img_dim_t   dim;

  // request intake
  lpcp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .mode_i, .point_x_i, .point_y_i, .point_z_i,
    .coef_index_i, .coef_value_i,
    .q_full_i(q_full), .q_valid_i(q_valid), .back_busy_i(back_busy),
    .push_o(push), .point_o(push_pt), .coef_o(coef), .dim_o(dim)
  );

  // decoupling queue
  lpcp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_pt), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_pt)
  );

  // arithmetic pipeline
  lpcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_pt), .pop_o(pop),
    .coef_i(coef), .dim_i(dim), .busy_o(back_busy),
    .out_valid_o, .out_stall_i, .cam_x_o, .cam_y_o, .cam_z_o
  );

endmodule

// File: hdl/lpcp_checker.sv
// ----------------------------------------------------------------------------
// lpcp_checker
// port-level checks for the lidar point camera projection block
// ----------------------------------------------------------------------------
module lpcp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 mode_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [lpcp_pkg::POINT_W-1:0]  cam_x_o,
  input logic signed [lpcp_pkg::POINT_W-1:0]  cam_y_o,
  input logic signed [lpcp_pkg::POINT_W-1:0]  cam_z_o
);

  logic acc_load;
  assign acc_load = in_valid_i && !in_stall_o && (mode_i == lpcp_pkg::MODE_LOAD);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cam_x_o) &&
    $stable(cam_y_o) && $stable(cam_z_o))
    else $error("result dropped or changed under stall");

  // reset clears the result valid
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid in reset");

  // a load only goes in on an empty pipeline, so no new result follows it
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_load |=> !$rose(out_valid_o))
    else $error("load accepted with points in flight");

endmodule

bind lidar_point_camera_projection lpcp_checker u_lpcp_checker (.*);
